// ----- hw/rtl/segment_pair_intersection_test_assert.svh -----
// ----------------------------------------------------------------------------
// segment_pair_intersection_test_assert.svh
// assertion macros for the segment pair test rtl, used by spit_cmp
// ----------------------------------------------------------------------------
`ifndef SEGMENT_PAIR_INTERSECTION_TEST_ASSERT_SVH
`define SEGMENT_PAIR_INTERSECTION_TEST_ASSERT_SVH

// condition implies consequence in the same cycle
`define SPIT_ASSERT_SAME(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define SPIT_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/spit_pkg.sv -----
// ----------------------------------------------------------------------------
// spit_pkg
// shared constants and types of the segment pair intersection test
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spit_pkg;

  // default coordinate width
  localparam int COORD_BITS_DEF = 16;

  // product slots carried from the multiply stage to the sum stage
  localparam int PROD_N    = 12;
  localparam int P_DS_DY   = 0;
  localparam int P_DX_DT   = 1;
  localparam int P_DS_TY   = 2;
  localparam int P_DT_SX   = 3;
  localparam int P_DX_TY   = 4;
  localparam int P_DY_SX   = 5;
  localparam int P_DX_DX   = 6;
  localparam int P_DY_DY   = 7;
  localparam int P_SX_DX   = 8;
  localparam int P_TY_DY   = 9;
  localparam int P_EX_DX   = 10;
  localparam int P_EY_DY   = 11;

  // pipeline control handed to each stage
  typedef struct packed {
    logic adv;  // whole pipeline moves this cycle
    logic vld;  // item valid at the stage input
  } spit_stg_t;

endpackage

// ----- hw/rtl/spit_if.sv -----
// ----------------------------------------------------------------------------
// spit_if
// valid/ready channels for segment pairs and intersection results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface spit_in_if #(
  parameter int COORD_BITS = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] a_start_x;
  logic signed [COORD_BITS-1:0] a_start_y;
  logic signed [COORD_BITS-1:0] a_end_x;
  logic signed [COORD_BITS-1:0] a_end_y;
  logic signed [COORD_BITS-1:0] b_start_x;
  logic signed [COORD_BITS-1:0] b_start_y;
  logic signed [COORD_BITS-1:0] b_end_x;
  logic signed [COORD_BITS-1:0] b_end_y;

  modport source (
    output valid, a_start_x, a_start_y, a_end_x, a_end_y,
           b_start_x, b_start_y, b_end_x, b_end_y,
    input  ready
  );
  modport sink (
    input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
           b_start_x, b_start_y, b_end_x, b_end_y,
    output ready
  );
endinterface

interface spit_out_if ();
  logic valid;
  logic ready;
  logic intersects;

  modport source (output valid, intersects, input ready);
  modport sink (input valid, intersects, output ready);
endinterface

// ----- hw/rtl/spit_diff.sv -----
// ----------------------------------------------------------------------------
// spit_diff
// stage 1: coordinate differences and degenerate segment a flag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spit_diff #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  spit_pkg::spit_stg_t          ctl,
  input  logic signed [COORD_BITS-1:0] a_start_x,
  input  logic signed [COORD_BITS-1:0] a_start_y,
  input  logic signed [COORD_BITS-1:0] a_end_x,
  input  logic signed [COORD_BITS-1:0] a_end_y,
  input  logic signed [COORD_BITS-1:0] b_start_x,
  input  logic signed [COORD_BITS-1:0] b_start_y,
  input  logic signed [COORD_BITS-1:0] b_end_x,
  input  logic signed [COORD_BITS-1:0] b_end_y,
  output logic                         vld_r,
  output logic                         deg_r,
  output logic signed [COORD_BITS:0]   dx_r,
  output logic signed [COORD_BITS:0]   dy_r,
  output logic signed [COORD_BITS:0]   ds_r,
  output logic signed [COORD_BITS:0]   dt_r,
  output logic signed [COORD_BITS:0]   sx_r,
  output logic signed [COORD_BITS:0]   ty_r,
  output logic signed [COORD_BITS:0]   ex_r,
  output logic signed [COORD_BITS:0]   ey_r
);
  import spit_pkg::*;

  localparam int CW = COORD_BITS;
  localparam int DW = COORD_BITS + 1;

  logic signed [DW-1:0] x1, y1, x2, y2, s1, t1, s2, t2;
  logic signed [DW-1:0] dx_nxt, dy_nxt, ds_nxt, dt_nxt;
  logic signed [DW-1:0] sx_nxt, ty_nxt, ex_nxt, ey_nxt;
  logic                 deg_nxt;

  // sign extend by one bit so the differences cannot wrap
  assign x1 = $signed({a_start_x[CW-1], a_start_x});
  assign y1 = $signed({a_start_y[CW-1], a_start_y});
  assign x2 = $signed({a_end_x[CW-1], a_end_x});
  assign y2 = $signed({a_end_y[CW-1], a_end_y});
  assign s1 = $signed({b_start_x[CW-1], b_start_x});
  assign t1 = $signed({b_start_y[CW-1], b_start_y});
  assign s2 = $signed({b_end_x[CW-1], b_end_x});
  assign t2 = $signed({b_end_y[CW-1], b_end_y});

  // direction vectors and offsets of b endpoints from a start
  always_comb begin
    dx_nxt  = x2 - x1;
    dy_nxt  = y2 - y1;
    ds_nxt  = s2 - s1;
    dt_nxt  = t2 - t1;
    sx_nxt  = s1 - x1;
    ty_nxt  = t1 - y1;
    ex_nxt  = s2 - x1;
    ey_nxt  = t2 - y1;
    deg_nxt = (a_start_x == a_end_x) && (a_start_y == a_end_y);
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.adv) begin
      vld_r <= ctl.vld;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      deg_r <= deg_nxt;
      dx_r  <= dx_nxt;
      dy_r  <= dy_nxt;
      ds_r  <= ds_nxt;
      dt_r  <= dt_nxt;
      sx_r  <= sx_nxt;
      ty_r  <= ty_nxt;
      ex_r  <= ex_nxt;
      ey_r  <= ey_nxt;
    end
  end

endmodule

// ----- hw/rtl/spit_prod.sv -----
// ----------------------------------------------------------------------------
// spit_prod
// stage 2: the twelve products behind the cross and dot products
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spit_prod #(
  parameter int COORD_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  spit_pkg::spit_stg_t              ctl,
  input  logic                             deg,
  input  logic signed [COORD_BITS:0]       dx,
  input  logic signed [COORD_BITS:0]       dy,
  input  logic signed [COORD_BITS:0]       ds,
  input  logic signed [COORD_BITS:0]       dt,
  input  logic signed [COORD_BITS:0]       sx,
  input  logic signed [COORD_BITS:0]       ty,
  input  logic signed [COORD_BITS:0]       ex,
  input  logic signed [COORD_BITS:0]       ey,
  output logic                             vld_r,
  output logic                             deg_r,
  output logic signed [2*COORD_BITS+1:0]   prod_r [spit_pkg::PROD_N]
);
  import spit_pkg::*;

  localparam int PW = 2 * COORD_BITS + 2;

  logic signed [PW-1:0] prod_nxt [PROD_N];

  // one multiplier per slot, operands sign extended to the product width
  always_comb begin
    prod_nxt[P_DS_DY] = PW'(ds) * PW'(dy);
    prod_nxt[P_DX_DT] = PW'(dx) * PW'(dt);
    prod_nxt[P_DS_TY] = PW'(ds) * PW'(ty);
    prod_nxt[P_DT_SX] = PW'(dt) * PW'(sx);
    prod_nxt[P_DX_TY] = PW'(dx) * PW'(ty);
    prod_nxt[P_DY_SX] = PW'(dy) * PW'(sx);
    prod_nxt[P_DX_DX] = PW'(dx) * PW'(dx);
    prod_nxt[P_DY_DY] = PW'(dy) * PW'(dy);
    prod_nxt[P_SX_DX] = PW'(sx) * PW'(dx);
    prod_nxt[P_TY_DY] = PW'(ty) * PW'(dy);
    prod_nxt[P_EX_DX] = PW'(ex) * PW'(dx);
    prod_nxt[P_EY_DY] = PW'(ey) * PW'(dy);
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.adv) begin
      vld_r <= ctl.vld;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      deg_r  <= deg;
      prod_r <= prod_nxt;
    end
  end

endmodule

// ----- hw/rtl/spit_sum.sv -----
// ----------------------------------------------------------------------------
// spit_sum
// stage 3: determinant, crossing numerators and projections onto a
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spit_sum #(
  parameter int COORD_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  spit_pkg::spit_stg_t              ctl,
  input  logic                             deg,
  input  logic signed [2*COORD_BITS+1:0]   prod [spit_pkg::PROD_N],
  output logic                             vld_r,
  output logic                             deg_r,
  output logic signed [2*COORD_BITS+2:0]   det_r,
  output logic signed [2*COORD_BITS+2:0]   pn_r,
  output logic signed [2*COORD_BITS+2:0]   qn_r,
  output logic signed [2*COORD_BITS+2:0]   len_r,
  output logic signed [2*COORD_BITS+2:0]   tp_r,
  output logic signed [2*COORD_BITS+2:0]   tq_r
);
  import spit_pkg::*;

  localparam int SW = 2 * COORD_BITS + 3;

  logic signed [SW-1:0] det_nxt, pn_nxt, qn_nxt, len_nxt, tp_nxt, tq_nxt;

  // one extra bit keeps every sum and difference exact
  always_comb begin
    det_nxt = SW'(prod[P_DS_DY]) - SW'(prod[P_DX_DT]);
    pn_nxt  = SW'(prod[P_DS_TY]) - SW'(prod[P_DT_SX]);
    qn_nxt  = SW'(prod[P_DX_TY]) - SW'(prod[P_DY_SX]);
    len_nxt = SW'(prod[P_DX_DX]) + SW'(prod[P_DY_DY]);
    tp_nxt  = SW'(prod[P_SX_DX]) + SW'(prod[P_TY_DY]);
    tq_nxt  = SW'(prod[P_EX_DX]) + SW'(prod[P_EY_DY]);
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.adv) begin
      vld_r <= ctl.vld;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      deg_r <= deg;
      det_r <= det_nxt;
      pn_r  <= pn_nxt;
      qn_r  <= qn_nxt;
      len_r <= len_nxt;
      tp_r  <= tp_nxt;
      tq_r  <= tq_nxt;
    end
  end

endmodule

// ----- hw/rtl/spit_cmp.sv -----
// ----------------------------------------------------------------------------
// spit_cmp
// stages 4 and 5: sign-aware compares, then the final decision register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "segment_pair_intersection_test_assert.svh"

module spit_cmp #(
  parameter int COORD_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  spit_pkg::spit_stg_t              ctl,
  input  logic                             deg,
  input  logic signed [2*COORD_BITS+2:0]   det,
  input  logic signed [2*COORD_BITS+2:0]   pn,
  input  logic signed [2*COORD_BITS+2:0]   qn,
  input  logic signed [2*COORD_BITS+2:0]   len,
  input  logic signed [2*COORD_BITS+2:0]   tp,
  input  logic signed [2*COORD_BITS+2:0]   tq,
  output logic                             vld_r,
  output logic                             res_r
);
  import spit_pkg::*;

  // compare flags of one item
  typedef struct packed {
    logic deg;
    logic det_pos;
    logic det_zero;
    logic pn_pos;
    logic pn_neg;
    logic pn_lt_det;
    logic pn_gt_det;
    logic qn_pos;
    logic qn_neg;
    logic qn_lt_det;
    logic qn_gt_det;
    logic qn_zero;
    logic tp_ne_tq;
    logic tp_lt_len;
    logic tq_lt_len;
    logic tp_pos;
    logic tq_pos;
  } spit_flags_t;

  spit_flags_t flg_nxt, flg_r;
  logic        flg_vld_r;
  logic        cross_ok, overlap_ok, res_nxt;

  // independent compares, all side by side
  always_comb begin
    flg_nxt.deg       = deg;
    flg_nxt.det_pos   = (det > 0);
    flg_nxt.det_zero  = (det == 0);
    flg_nxt.pn_pos    = (pn > 0);
    flg_nxt.pn_neg    = (pn < 0);
    flg_nxt.pn_lt_det = (pn < det);
    flg_nxt.pn_gt_det = (pn > det);
    flg_nxt.qn_pos    = (qn > 0);
    flg_nxt.qn_neg    = (qn < 0);
    flg_nxt.qn_lt_det = (qn < det);
    flg_nxt.qn_gt_det = (qn > det);
    flg_nxt.qn_zero   = (qn == 0);
    flg_nxt.tp_ne_tq  = (tp != tq);
    flg_nxt.tp_lt_len = (tp < len);
    flg_nxt.tq_lt_len = (tq < len);
    flg_nxt.tp_pos    = (tp > 0);
    flg_nxt.tq_pos    = (tq > 0);
  end

  // flag stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flg_vld_r <= 1'b0;
    end else if (ctl.adv) begin
      flg_vld_r <= ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      flg_r <= flg_nxt;
    end
  end

  // both crossing parameters strictly inside (0, 1), sign taken from det
  always_comb begin
    if (flg_r.det_pos) begin
      cross_ok = flg_r.pn_pos && flg_r.pn_lt_det && flg_r.qn_pos && flg_r.qn_lt_det;
    end else begin
      cross_ok = flg_r.pn_neg && flg_r.pn_gt_det && flg_r.qn_neg && flg_r.qn_gt_det;
    end
  end

  // collinear: projected b interval has length and meets (0, len)
  assign overlap_ok = flg_r.qn_zero && flg_r.tp_ne_tq &&
                      (flg_r.tp_lt_len || flg_r.tq_lt_len) &&
                      (flg_r.tp_pos || flg_r.tq_pos);

  always_comb begin
    priority if (flg_r.deg) begin
      res_nxt = 1'b0;
    end else if (!flg_r.det_zero) begin
      res_nxt = cross_ok;
    end else begin
      res_nxt = overlap_ok;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl.adv) begin
      vld_r <= flg_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      res_r <= res_nxt;
    end
  end

  // checks
  `SPIT_ASSERT_NEXT(a_stall_hold, rst_n && !ctl.adv,
                    $stable(vld_r) && $stable(res_r) && $stable(flg_vld_r),
                    "pipeline moved during a stall")
  `SPIT_ASSERT_NEXT(a_deg_zero, rst_n && ctl.adv && flg_vld_r && flg_r.deg, !res_r,
                    "degenerate segment a gave a hit")
  `SPIT_ASSERT_NEXT(a_parallel_zero,
                    rst_n && ctl.adv && flg_vld_r && flg_r.det_zero && !flg_r.qn_zero,
                    !res_r, "parallel distinct lines gave a hit")

endmodule

// ----- hw/rtl/segment_pair_intersection_test.sv -----
// ----------------------------------------------------------------------------
// segment_pair_intersection_test
// exact 2-d segment pair crossing and collinear overlap test
// ----------------------------------------------------------------------------
//  channel  dir  payload                                     handshake
//  in_ch    in   a/b start/end x/y, COORD_BITS signed each   valid/ready
//  out_ch   out  intersects, 1 bit                           valid/ready
//
//  five register stages: differences, products, sums, compares, decision
//  one item per cycle while out_ch is not stalled; each result is held until out_ch takes it
//  the product stage sets the critical path: one (COORD_BITS+1)-bit multiply
//  a stall on out_ch holds every stage in place; no item is dropped
//  reset clears all valid bits, payload registers are not reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_pair_intersection_test #(
  parameter int COORD_BITS = spit_pkg::COORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  spit_in_if.sink   in_ch,
  spit_out_if.source out_ch
);
  import spit_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * COORD_BITS + 2;
  localparam int SW = 2 * COORD_BITS + 3;

  logic      adv;
  spit_stg_t c1, c2, c3, c4;

  logic                 v1, deg1;
  logic signed [DW-1:0] dx1, dy1, ds1, dt1, sx1, ty1, ex1, ey1;
  logic                 v2, deg2;
  logic signed [PW-1:0] prod2 [PROD_N];
  logic                 v3, deg3;
  logic signed [SW-1:0] det3, pn3, qn3, len3, tp3, tq3;
  logic                 v5, res5;

  // whole pipeline advances unless a result is waiting and blocked
  assign adv         = !v5 || out_ch.ready;
  assign in_ch.ready = adv;

  always_comb begin
    c1 = '{adv: adv, vld: in_ch.valid};
    c2 = '{adv: adv, vld: v1};
    c3 = '{adv: adv, vld: v2};
    c4 = '{adv: adv, vld: v3};
  end

  spit_diff #(.COORD_BITS(COORD_BITS)) u_diff (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (c1),
    .a_start_x (in_ch.a_start_x),
    .a_start_y (in_ch.a_start_y),
    .a_end_x   (in_ch.a_end_x),
    .a_end_y   (in_ch.a_end_y),
    .b_start_x (in_ch.b_start_x),
    .b_start_y (in_ch.b_start_y),
    .b_end_x   (in_ch.b_end_x),
    .b_end_y   (in_ch.b_end_y),
    .vld_r     (v1),
    .deg_r     (deg1),
    .dx_r      (dx1),
    .dy_r      (dy1),
    .ds_r      (ds1),
    .dt_r      (dt1),
    .sx_r      (sx1),
    .ty_r      (ty1),
    .ex_r      (ex1),
    .ey_r      (ey1)
  );

  spit_prod #(.COORD_BITS(COORD_BITS)) u_prod (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (c2),
    .deg    (deg1),
    .dx     (dx1),
    .dy     (dy1),
    .ds     (ds1),
    .dt     (dt1),
    .sx     (sx1),
    .ty     (ty1),
    .ex     (ex1),
    .ey     (ey1),
    .vld_r  (v2),
    .deg_r  (deg2),
    .prod_r (prod2)
  );

  spit_sum #(.COORD_BITS(COORD_BITS)) u_sum (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (c3),
    .deg   (deg2),
    .prod  (prod2),
    .vld_r (v3),
    .deg_r (deg3),
    .det_r (det3),
    .pn_r  (pn3),
    .qn_r  (qn3),
    .len_r (len3),
    .tp_r  (tp3),
    .tq_r  (tq3)
  );

  spit_cmp #(.COORD_BITS(COORD_BITS)) u_cmp (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (c4),
    .deg   (deg3),
    .det   (det3),
    .pn    (pn3),
    .qn    (qn3),
    .len   (len3),
    .tp    (tp3),
    .tq    (tq3),
    .vld_r (v5),
    .res_r (res5)
  );

  // result channel
  assign out_ch.valid      = v5;
  assign out_ch.intersects = res5;

endmodule
